// File: sv/brf_pkg.sv
package brf_pkg;

  localparam int CountW = 7;
  localparam int ByteW  = 8;
  localparam int TotalW = 48;

  localparam logic [CountW-1:0] CapReset = 7'd64;
  localparam logic [CountW-1:0] MaxRes   = 7'd64;

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_POP   = 3'd3,
    CMD_END   = 3'd4
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_t;

  // status carried with every result through the output pipeline
  typedef struct packed {
    logic              byte_valid;
    logic              last;
    logic              accepted;
    logic [CountW-1:0] occupancy;
    logic [CountW-1:0] free_space;
    logic [TotalW-1:0] total_written;
    logic [TotalW-1:0] total_read;
    logic              input_closed;
    logic              end_of_stream;
  } res_t;

endpackage

// File: sv/brf_ram.sv
module brf_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [brf_pkg::ByteW-1:0]   wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [brf_pkg::ByteW-1:0]   rdata
);

  logic [brf_pkg::ByteW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/brf_ctrl.sv
module brf_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   command,
  input  logic [brf_pkg::ByteW-1:0]    data_byte,
  input  logic [brf_pkg::CountW-1:0]   length,
  input  logic                         cfg_we,
  input  logic [brf_pkg::CountW-1:0]   cfg_wdata,
  input  logic                         slot_free,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [brf_pkg::ByteW-1:0]    ram_wdata,
  output logic                         ram_re,
  output logic [AW-1:0]                ram_raddr,
  output logic                         issue,
  output brf_pkg::res_t                issue_res
);

  localparam int CW     = brf_pkg::CountW;
  localparam int TW     = brf_pkg::TotalW;
  localparam int SW     = ((AW > CW) ? AW : CW) + 1;
  localparam int CapMax = (DEPTH < 127) ? DEPTH : 127;

  brf_pkg::state_t state, state_next;

  logic [CW-1:0] cap_reg;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] held, held_next;
  logic [TW-1:0] wr_total, wr_total_next;
  logic [TW-1:0] rd_total, rd_total_next;
  logic          closed, closed_next;
  logic [AW-1:0] rptr;
  logic [CW-1:0] remaining;

  logic [CW-1:0] cap_eff;
  logic          accept;
  logic          room;
  logic          is_rdpk;
  logic [CW-1:0] n_held;
  logic [CW-1:0] n_rd;

  // (base + off) mod cap, valid while base + off < 2 * cap
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off,
                                             input logic [CW-1:0] cap);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(cap)) begin
      sum = sum - SW'(cap);
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    cap_eff = cap_reg;
    if (cap_reg == '0) begin
      cap_eff = 7'd1;
    end else if (cap_reg > CW'(CapMax)) begin
      cap_eff = CW'(CapMax);
    end
  end

  assign in_stall = (state == brf_pkg::ST_STREAM) || !slot_free;
  assign accept   = in_valid && !in_stall;
  assign room     = held < cap_eff;
  assign is_rdpk  = (command == brf_pkg::CMD_READ) || (command == brf_pkg::CMD_PEEK);
  assign n_held   = (length < held) ? length : held;
  assign n_rd     = (n_held > brf_pkg::MaxRes) ? brf_pkg::MaxRes : n_held;

  // architectural state after the transaction
  always_comb begin
    head_next     = head;
    held_next     = held;
    wr_total_next = wr_total;
    rd_total_next = rd_total;
    closed_next   = closed;
    if (accept) begin
      case (command)
        brf_pkg::CMD_WRITE: begin
          if (room) begin
            held_next     = held + 7'd1;
            wr_total_next = wr_total + 48'd1;
          end
        end
        brf_pkg::CMD_READ: begin
          head_next     = wrap_add(head, n_rd, cap_eff);
          held_next     = held - n_rd;
          rd_total_next = rd_total + TW'(n_rd);
        end
        brf_pkg::CMD_POP: begin
          head_next     = wrap_add(head, n_held, cap_eff);
          held_next     = held - n_held;
          rd_total_next = rd_total + TW'(n_held);
        end
        brf_pkg::CMD_END: begin
          closed_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      brf_pkg::ST_IDLE: begin
        if (accept && is_rdpk && (n_rd > 7'd1)) begin
          state_next = brf_pkg::ST_STREAM;
        end
      end
      brf_pkg::ST_STREAM: begin
        if (slot_free && (remaining == 7'd1)) begin
          state_next = brf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = brf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = wrap_add(head, held, cap_eff);
    ram_wdata  = data_byte;
    ram_re     = 1'b0;
    ram_raddr  = head;
    issue      = 1'b0;
    issue_res.byte_valid    = 1'b0;
    issue_res.last          = 1'b1;
    issue_res.accepted      = 1'b0;
    issue_res.occupancy     = held_next;
    issue_res.free_space    = cap_eff - held_next;
    issue_res.total_written = wr_total_next;
    issue_res.total_read    = rd_total_next;
    issue_res.input_closed  = closed_next;
    issue_res.end_of_stream = closed_next && (held_next == '0);
    case (state)
      brf_pkg::ST_IDLE: begin
        if (accept) begin
          issue = 1'b1;
          if (command == brf_pkg::CMD_WRITE) begin
            ram_we             = room;
            issue_res.accepted = room;
          end else if (is_rdpk && (n_rd != '0)) begin
            ram_re               = 1'b1;
            issue_res.byte_valid = 1'b1;
            issue_res.last       = (n_rd == 7'd1);
          end
        end
      end
      brf_pkg::ST_STREAM: begin
        ram_raddr = rptr;
        if (slot_free) begin
          ram_re               = 1'b1;
          issue                = 1'b1;
          issue_res.byte_valid = 1'b1;
          issue_res.last       = (remaining == 7'd1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brf_pkg::ST_IDLE;
      cap_reg   <= brf_pkg::CapReset;
      head      <= '0;
      held      <= '0;
      wr_total  <= '0;
      rd_total  <= '0;
      closed    <= 1'b0;
      remaining <= '0;
    end else begin
      state    <= state_next;
      wr_total <= wr_total_next;
      rd_total <= rd_total_next;
      closed   <= closed_next;
      if (cfg_we) begin
        // new capacity drops the held contents
        cap_reg <= cfg_wdata;
        head    <= '0;
        held    <= '0;
      end else begin
        head <= head_next;
        held <= held_next;
      end
      if (state == brf_pkg::ST_IDLE) begin
        if (accept && is_rdpk) begin
          remaining <= n_rd - 7'd1;
        end
      end else if (slot_free) begin
        remaining <= remaining - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == brf_pkg::ST_IDLE) begin
      rptr <= wrap_add(head, 7'd1, cap_eff);
    end else if (slot_free) begin
      rptr <= wrap_add(rptr, 7'd1, cap_eff);
    end
  end

endmodule

// File: sv/brf_resq.sv
module brf_resq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        issue,
  input  brf_pkg::res_t               issue_res,
  input  logic [brf_pkg::ByteW-1:0]   rdata,
  output logic                        slot_free,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [brf_pkg::ByteW-1:0]   out_byte,
  output brf_pkg::res_t               out_res
);

  logic          pend_valid;
  brf_pkg::res_t pend_res;
  logic          move;

  // pend stage lines up with the RAM read latency; the byte sits in rdata
  assign move      = pend_valid && (!out_valid || !out_stall);
  assign slot_free = !pend_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (issue) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_res <= issue_res;
    end
    if (move) begin
      out_res  <= pend_res;
      out_byte <= pend_res.byte_valid ? rdata : '0;
    end
  end

endmodule

// File: sv/byte_ring_fifo_stream.sv
// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_stall   command, data_byte, length
// out       source     out_valid / out_stall out_byte, byte_valid, last, accepted, occupancy,
//                                            free_space, total_written, total_read,
//                                            input_closed, end_of_stream
// cfg       sink       cfg_we                cfg_wdata (capacity)
//
// Write, pop, end input, single-byte read or peek: one transaction per cycle if not stalled.
// Read or peek of n bytes: one byte per cycle from the single RAM read port if not stalled.
// Results pass through the RAM read stage, then the output register.
// rst is synchronous; it clears head, counts, totals and the closed flag, not the RAM.
// Output stall backs up through the two result stages into in_stall.
module byte_ring_fifo_stream #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  command,
  input  logic [brf_pkg::ByteW-1:0]   data_byte,
  input  logic [brf_pkg::CountW-1:0]  length,
  input  logic                        cfg_we,
  input  logic [brf_pkg::CountW-1:0]  cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [brf_pkg::ByteW-1:0]   out_byte,
  output logic                        byte_valid,
  output logic                        last,
  output logic                        accepted,
  output logic [brf_pkg::CountW-1:0]  occupancy,
  output logic [brf_pkg::CountW-1:0]  free_space,
  output logic [brf_pkg::TotalW-1:0]  total_written,
  output logic [brf_pkg::TotalW-1:0]  total_read,
  output logic                        input_closed,
  output logic                        end_of_stream
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                      slot_free;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [brf_pkg::ByteW-1:0] ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [brf_pkg::ByteW-1:0] ram_rdata;
  logic                      issue;
  brf_pkg::res_t             issue_res;
  brf_pkg::res_t             out_res;

  brf_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .data_byte (data_byte),
    .length    (length),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .slot_free (slot_free),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .issue     (issue),
    .issue_res (issue_res)
  );

  brf_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  brf_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .issue_res (issue_res),
    .rdata     (ram_rdata),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_res   (out_res)
  );

  assign byte_valid    = out_res.byte_valid;
  assign last          = out_res.last;
  assign accepted      = out_res.accepted;
  assign occupancy     = out_res.occupancy;
  assign free_space    = out_res.free_space;
  assign total_written = out_res.total_written;
  assign total_read    = out_res.total_read;
  assign input_closed  = out_res.input_closed;
  assign end_of_stream = out_res.end_of_stream;

endmodule

// File: sv/brf_checker.sv
module brf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [brf_pkg::ByteW-1:0]   out_byte,
  input logic                        byte_valid,
  input logic                        last,
  input logic                        accepted,
  input logic [brf_pkg::CountW-1:0]  occupancy,
  input logic [brf_pkg::TotalW-1:0]  total_read,
  input logic                        input_closed,
  input logic                        end_of_stream
);

  a_rst_clears_out : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(total_read))
    else $error("stalled result changed");

  a_no_byte_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> (out_byte == '0) && last)
    else $error("status-only result carries a byte or no last mark");

  a_eos : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (end_of_stream == (input_closed && (occupancy == '0))))
    else $error("end of stream inconsistent with closed flag and occupancy");

  a_acc_write_only : assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> !byte_valid && (occupancy != '0))
    else $error("accepted write reports no held byte");

endmodule

bind byte_ring_fifo_stream brf_checker u_brf_checker (.*);

// File: bench/byte_ring_fifo_stream_tb.sv
module byte_ring_fifo_stream_tb;

  localparam int CycleLimit = 1_000_000;

  typedef struct packed {
    logic [brf_pkg::ByteW-1:0] out_byte;
    brf_pkg::res_t             st;
  } fifo_result_t;

  // Mirror of the ring: tracks contents, counts and the results each command is due to give
  class ring_mirror;
    logic [7:0]  store [64];
    int unsigned head;
    int unsigned held;
    logic [6:0]  cap_reg;
    logic [47:0] written;
    logic [47:0] drained;
    bit          closed;
    fifo_result_t due [$];
    int unsigned faults;

    function new();
      head = 0;
      held = 0;
      cap_reg = brf_pkg::CapReset;
      written = '0;
      drained = '0;
      closed = 1'b0;
      faults = 0;
    endfunction

    // capacity 0 behaves as 1, anything above the store depth as the depth
    function int unsigned span();
      if (cap_reg == 7'd0) return 1;
      if (cap_reg > 7'd64) return 64;
      return cap_reg;
    endfunction

    function void set_capacity(logic [6:0] v);
      cap_reg = v;
      head = 0;
      held = 0;
    endfunction

    function void post(logic [7:0] b, bit bv, bit lst, bit acc);
      fifo_result_t r;
      r.out_byte         = bv ? b : 8'd0;
      r.st.byte_valid    = bv;
      r.st.last          = lst;
      r.st.accepted      = acc;
      r.st.occupancy     = 7'(held);
      r.st.free_space    = 7'(span() - held);
      r.st.total_written = written;
      r.st.total_read    = drained;
      r.st.input_closed  = closed;
      r.st.end_of_stream = closed && (held == 0);
      due.push_back(r);
    endfunction

    function void take_command(logic [2:0] cmd, logic [7:0] data, logic [6:0] len);
      int unsigned c;
      int unsigned n;
      int unsigned i;
      bit          acc;
      logic [7:0]  got [64];
      c = span();
      case (cmd)
        brf_pkg::CMD_WRITE: begin
          acc = 1'b0;
          if (held < c) begin
            store[(head + held) % c] = data;
            held++;
            written++;
            acc = 1'b1;
          end
          post(8'd0, 1'b0, 1'b1, acc);
        end
        brf_pkg::CMD_READ, brf_pkg::CMD_PEEK: begin
          n = (len < held) ? len : held;
          if (n > 64) n = 64;
          for (i = 0; i < n; i++) got[i] = store[(head + i) % c];
          if (cmd == brf_pkg::CMD_READ) begin
            head = (head + n) % c;
            held -= n;
            drained += 48'(n);
          end
          if (n == 0) post(8'd0, 1'b0, 1'b1, 1'b0);
          else for (i = 0; i < n; i++) post(got[i], 1'b1, i + 1 == n, 1'b0);
        end
        brf_pkg::CMD_POP: begin
          n = (len < held) ? len : held;
          head = (head + n) % c;
          held -= n;
          drained += 48'(n);
          post(8'd0, 1'b0, 1'b1, 1'b0);
        end
        brf_pkg::CMD_END: begin
          closed = 1'b1;
          post(8'd0, 1'b0, 1'b1, 1'b0);
        end
        default: post(8'd0, 1'b0, 1'b1, 1'b0);
      endcase
    endfunction

    function void compare_field(string name, logic [47:0] want, logic [47:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        faults++;
      end
    endfunction

    function void match_result(fifo_result_t seen);
      fifo_result_t want;
      if (due.size() == 0) begin
        $error("out_byte: expected no transaction, got %0d", seen.out_byte);
        faults++;
        return;
      end
      want = due.pop_front();
      compare_field("out_byte", want.out_byte, seen.out_byte);
      compare_field("byte_valid", want.st.byte_valid, seen.st.byte_valid);
      compare_field("last", want.st.last, seen.st.last);
      compare_field("accepted", want.st.accepted, seen.st.accepted);
      compare_field("occupancy", want.st.occupancy, seen.st.occupancy);
      compare_field("free_space", want.st.free_space, seen.st.free_space);
      compare_field("total_written", want.st.total_written, seen.st.total_written);
      compare_field("total_read", want.st.total_read, seen.st.total_read);
      compare_field("input_closed", want.st.input_closed, seen.st.input_closed);
      compare_field("end_of_stream", want.st.end_of_stream, seen.st.end_of_stream);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid;
  logic                        in_stall;
  logic [2:0]                  command;
  logic [brf_pkg::ByteW-1:0]   data_byte;
  logic [brf_pkg::CountW-1:0]  length;
  logic                        cfg_we;
  logic [brf_pkg::CountW-1:0]  cfg_wdata;
  logic                        out_valid;
  logic                        out_stall;
  logic [brf_pkg::ByteW-1:0]   out_byte;
  logic                        byte_valid;
  logic                        last;
  logic                        accepted;
  logic [brf_pkg::CountW-1:0]  occupancy;
  logic [brf_pkg::CountW-1:0]  free_space;
  logic [brf_pkg::TotalW-1:0]  total_written;
  logic [brf_pkg::TotalW-1:0]  total_read;
  logic                        input_closed;
  logic                        end_of_stream;

  ring_mirror  mirror = new();
  bit          tx_quiet;
  bit          rx_quiet;
  int unsigned cycle_count;

  byte_ring_fifo_stream #(.DEPTH(64)) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .data_byte     (data_byte),
    .length        (length),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .last          (last),
    .accepted      (accepted),
    .occupancy     (occupancy),
    .free_space    (free_space),
    .total_written (total_written),
    .total_read    (total_read),
    .input_closed  (input_closed),
    .end_of_stream (end_of_stream)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : result_monitor
    fifo_result_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen.out_byte         = out_byte;
      seen.st.byte_valid    = byte_valid;
      seen.st.last          = last;
      seen.st.accepted      = accepted;
      seen.st.occupancy     = occupancy;
      seen.st.free_space    = free_space;
      seen.st.total_written = total_written;
      seen.st.total_read    = total_read;
      seen.st.input_closed  = input_closed;
      seen.st.end_of_stream = end_of_stream;
      mirror.match_result(seen);
    end
  end

  // output side: random stall before each transaction, with quiet stretches
  initial begin : sink_pacing
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      if ($urandom_range(0, 11) == 0) rx_quiet = !rx_quiet;
      hold = rx_quiet ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // entered and left at a falling edge
  task automatic send_command(logic [2:0] cmd, logic [7:0] data, logic [6:0] len);
    int unsigned gap;
    if ($urandom_range(0, 11) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command   = cmd;
    data_byte = data;
    length    = len;
    in_valid  = 1'b1;
    do @(posedge clk); while (in_stall);
    mirror.take_command(cmd, data, len);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (mirror.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(logic [6:0] v);
    settle();
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(posedge clk);
    mirror.set_capacity(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly writes and reads sized near the fill level, some oversize requests and junk codes
  task automatic random_command();
    int unsigned pick;
    int unsigned reach;
    logic [2:0]  cmd;
    logic [6:0]  len;
    pick = $urandom_range(0, 99);
    if (pick < 50)      cmd = brf_pkg::CMD_WRITE;
    else if (pick < 70) cmd = brf_pkg::CMD_READ;
    else if (pick < 80) cmd = brf_pkg::CMD_PEEK;
    else if (pick < 90) cmd = brf_pkg::CMD_POP;
    else if (pick < 95) cmd = brf_pkg::CMD_END;
    else                cmd = 3'(brf_pkg::CMD_END) + 3'(1 + $urandom_range(0, 2));
    reach = mirror.held + 2;
    if (reach > 64) reach = 64;
    case ($urandom_range(0, 9))
      0:       len = 7'($urandom_range(0, 127));
      1:       len = 7'd64;
      default: len = 7'($urandom_range(0, reach));
    endcase
    send_command(cmd, 8'($urandom_range(0, 255)), len);
  endtask

  initial begin : stimulus
    logic [6:0]  caps [6];
    int unsigned runs [6];
    caps = '{7'd5, 7'd127, 7'd3, 7'd17, 7'd100, 7'd2};
    runs = '{2, 2, 1, 2, 1, 2};
    in_valid  = 1'b0;
    command   = brf_pkg::CMD_WRITE;
    data_byte = '0;
    length    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty buffer, then oversize requests, end of input and writes after it
    send_command(brf_pkg::CMD_READ, 8'd0, 7'd0);
    send_command(brf_pkg::CMD_PEEK, 8'd0, 7'd5);
    send_command(brf_pkg::CMD_POP, 8'd0, 7'd3);
    send_command(3'(brf_pkg::CMD_END) + 3'd1, 8'd0, 7'd0);
    send_command(brf_pkg::CMD_WRITE, 8'h00, 7'd0);
    send_command(brf_pkg::CMD_WRITE, 8'hFF, 7'd127);
    send_command(brf_pkg::CMD_WRITE, 8'hA5, 7'd0);
    send_command(brf_pkg::CMD_WRITE, 8'h5A, 7'd0);
    send_command(brf_pkg::CMD_PEEK, 8'd0, 7'd127);
    send_command(brf_pkg::CMD_READ, 8'd0, 7'd2);
    send_command(brf_pkg::CMD_POP, 8'd0, 7'd64);
    send_command(brf_pkg::CMD_END, 8'd0, 7'd0);
    send_command(brf_pkg::CMD_WRITE, 8'h3C, 7'd0);
    send_command(brf_pkg::CMD_READ, 8'd0, 7'd1);
    send_command(brf_pkg::CMD_READ, 8'd0, 7'd1);

    write_capacity(7'd1);
    send_command(brf_pkg::CMD_WRITE, 8'h11, 7'd0);
    send_command(brf_pkg::CMD_WRITE, 8'h22, 7'd0);
    send_command(brf_pkg::CMD_PEEK, 8'd0, 7'd1);
    send_command(brf_pkg::CMD_READ, 8'd0, 7'd1);

    write_capacity(7'd0);
    send_command(brf_pkg::CMD_WRITE, 8'h81, 7'd0);
    send_command(brf_pkg::CMD_WRITE, 8'h7E, 7'd0);
    send_command(brf_pkg::CMD_READ, 8'd0, 7'd3);

    // full ring, overflow, then one read of the whole lot
    write_capacity(7'd64);
    repeat (66) send_command(brf_pkg::CMD_WRITE, 8'($urandom_range(0, 255)), 7'd0);
    send_command(brf_pkg::CMD_READ, 8'd0, 7'd127);
    repeat (4) random_command();

    for (int p = 0; p < 6; p++) begin
      write_capacity(caps[p]);
      repeat (runs[p]) random_command();
    end

    settle();
    if (mirror.faults == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
